// ===== sv/badc_pkg.sv =====
// Shared types and constants for the bridge converter serial reader.
`timescale 1ns / 1ps
package badc_pkg;

  // Converter word and frame geometry.
  localparam int unsigned DATA_BITS = 24;
  localparam int unsigned NET_W     = 25;
  localparam int unsigned PULSE_W   = 5;
  localparam int unsigned GAIN_W    = 2;
  localparam int unsigned AVG_W     = 7;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE_OFFSET   = 2'd2;

  // Frame phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_GAIN = 2'd2;

  // Last data pulse index and the bit that is inverted for offset binary.
  localparam logic [PULSE_W-1:0]   LAST_DATA_PULSE = 5'd23;
  localparam logic [DATA_BITS-1:0] TOP_BIT         = 24'h800000;

  // What the frame sequencer reports for the tick being taken.
  typedef struct packed {
    logic                 sck;
    logic                 done;
    logic [DATA_BITS-1:0] raw;
  } badc_frame_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } badc_div_stat_t;

endpackage

// ===== sv/badc_frame.sv =====
// Serial frame sequencer: drives the clock pulses and shifts in the data word.
`timescale 1ns / 1ps
module badc_frame
  import badc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              dout_level,
  input  logic [GAIN_W-1:0] gain_pulses,
  output badc_frame_t       frm
);

  logic [1:0]           phase_r, phase_nxt;
  logic [PULSE_W-1:0]   pulse_r, pulse_nxt, pulse_inc;
  logic                 clk_high_r, clk_high_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;

  assign pulse_inc = pulse_r + 1'b1;

  // Next state for one tick, and what this tick drives.
  always_comb begin
    phase_nxt    = phase_r;
    pulse_nxt    = pulse_r;
    clk_high_nxt = clk_high_r;
    shift_nxt    = shift_r;
    frm.sck      = 1'b0;
    frm.done     = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (!dout_level) begin
        phase_nxt    = PH_DATA;
        pulse_nxt    = '0;
        clk_high_nxt = 1'b0;
        shift_nxt    = '0;
      end
    end else if (!clk_high_r) begin
      frm.sck      = 1'b1;
      clk_high_nxt = 1'b1;
    end else begin
      clk_high_nxt = 1'b0;
      pulse_nxt    = pulse_inc;
      if (phase_r == PH_DATA) begin
        shift_nxt = {shift_r[DATA_BITS-2:0], dout_level};
        if (pulse_r == LAST_DATA_PULSE) begin
          pulse_nxt = '0;
          if (gain_pulses == '0) begin
            frm.done  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_GAIN;
          end
        end
      end else if (pulse_inc >= PULSE_W'(gain_pulses)) begin
        frm.done  = 1'b1;
        phase_nxt = PH_IDLE;
        pulse_nxt = '0;
      end
    end
    frm.raw = shift_nxt ^ TOP_BIT;
  end

  // State advances only on a taken tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      pulse_r    <= '0;
      clk_high_r <= 1'b0;
      shift_r    <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      pulse_r    <= pulse_nxt;
      clk_high_r <= clk_high_nxt;
      shift_r    <= shift_nxt;
    end
  end

endmodule

// ===== sv/badc_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module badc_div
  import badc_pkg::*;
#(
  parameter int unsigned SUM_W = 30,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             ack,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output badc_div_stat_t   stat
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r, done_r;
  logic [CNT_W:0]    trial, diff;
  logic              qbit;

  // One trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, den_r};
    qbit    = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // Data path: the dividend shifts out of quo_r as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[SUM_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  // Iteration count and handshake with the controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= STEP_W'(SUM_W);
    end else if (run_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ack) begin
      done_r <= 1'b0;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = run_r;
  assign stat.done = done_r;

endmodule

// ===== sv/bridge_adc_serial_reader_top.sv =====
// Top level of the bridge converter serial reader with averaging and tare.
`timescale 1ns / 1ps
// Master for a two-wire 24-bit bridge converter. Every input item is one tick
// of the serial line and carries the sampled data level; every item yields
// exactly one result item with the clock level to drive for that tick and,
// when a frame completes, the offset-binary raw code. Raw codes are summed and,
// once average_count of them (clamped to 1..MAX_AVERAGE) are in, the truncated
// mean minus tare_offset is reported as net_value in the same result item.
// A tick that completes an average waits for the bit-serial divider that forms
// the mean; input is stalled meanwhile. Results sit in an output register, so a
// new tick is taken in the cycle that the previous result leaves; a result held
// by a stalled receiver stalls the input.
module bridge_adc_serial_reader_top
  import badc_pkg::*;
#(
  parameter int unsigned MAX_AVERAGE = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_dout_level,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_sck_level,
  output logic                    out_raw_valid,
  output logic [DATA_BITS-1:0]    out_raw_code,
  output logic                    out_net_valid,
  output logic signed [NET_W-1:0] out_net_value
);

  localparam int unsigned SUM_W = DATA_BITS + $clog2(MAX_AVERAGE);
  localparam int unsigned CNT_W = $clog2(MAX_AVERAGE + 1);
  localparam int unsigned EFF_W = (CNT_W > AVG_W) ? CNT_W : AVG_W;

  // Controller states.
  localparam logic ST_RUN = 1'b0;
  localparam logic ST_DIV = 1'b1;

  logic                 state_r, state_nxt;
  logic [GAIN_W-1:0]    gain_r;
  logic [AVG_W-1:0]     avg_r;
  logic [DATA_BITS-1:0] tare_r;
  logic [SUM_W-1:0]     sum_r, sum_add;
  logic [CNT_W-1:0]     cnt_r, cnt_add;
  logic [DATA_BITS-1:0] pend_raw_r;

  logic                 out_valid_r, out_sck_r, out_raw_valid_r, out_net_valid_r;
  logic [DATA_BITS-1:0] out_raw_r;
  logic [NET_W-1:0]     out_net_r;

  logic                 in_acc, out_free, need_net, div_take;
  logic [EFF_W-1:0]     eff;
  logic [SUM_W-1:0]     quotient;
  logic [NET_W-1:0]     net_calc;
  badc_frame_t          frm;
  badc_div_stat_t       div_stat;

  // Handshake.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_DIV) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_W'(1);
      avg_r  <= AVG_W'(1);
      tare_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_PULSES:   gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_AVERAGE_COUNT: avg_r  <= cfg_wdata[AVG_W-1:0];
        CFG_TARE_OFFSET:   tare_r <= cfg_wdata[DATA_BITS-1:0];
        default: ;
      endcase
    end
  end

  badc_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .dout_level  (in_dout_level),
    .gain_pulses (gain_r),
    .frm         (frm)
  );

  // Effective averaging count, clamped to 1..MAX_AVERAGE.
  always_comb begin
    eff = (avg_r == '0) ? EFF_W'(1) : EFF_W'(avg_r);
    if (eff > EFF_W'(MAX_AVERAGE)) begin
      eff = EFF_W'(MAX_AVERAGE);
    end
  end

  // Accumulator including the code from the frame finishing this tick.
  assign sum_add  = sum_r + SUM_W'(frm.raw);
  assign cnt_add  = cnt_r + 1'b1;
  assign need_net = frm.done && (EFF_W'(cnt_add) >= eff);
  assign div_take = (state_r == ST_DIV) && div_stat.done && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (in_acc && frm.done) begin
      if (need_net) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_add;
        cnt_r <= cnt_add;
      end
    end
  end

  badc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc && need_net),
    .ack      (div_take),
    .dividend (sum_add),
    .divisor  (cnt_add),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Mean minus tare, wrapped to the result width.
  assign net_calc = {1'b0, quotient[DATA_BITS-1:0]} - {1'b0, tare_r};

  // Controller: waits in ST_DIV until the mean has gone to the output.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN:  if (in_acc && need_net) state_nxt = ST_DIV;
      ST_DIV:  if (div_take) state_nxt = ST_RUN;
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Raw code held while the mean is formed.
  always_ff @(posedge clk) begin
    if (in_acc && need_net) begin
      pend_raw_r <= frm.raw;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && !need_net) begin
      out_valid_r <= 1'b1;
    end else if (div_take) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !need_net) begin
      out_sck_r       <= frm.sck;
      out_raw_valid_r <= frm.done;
      out_raw_r       <= frm.done ? frm.raw : '0;
      out_net_valid_r <= 1'b0;
      out_net_r       <= '0;
    end else if (div_take) begin
      out_sck_r       <= 1'b0;
      out_raw_valid_r <= 1'b1;
      out_raw_r       <= pend_raw_r;
      out_net_valid_r <= 1'b1;
      out_net_r       <= net_calc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sck_level = out_sck_r;
  assign out_raw_valid = out_raw_valid_r;
  assign out_raw_code  = out_raw_r;
  assign out_net_valid = out_net_valid_r;
  assign out_net_value = out_net_r;

  // The divider only runs while the controller waits for the mean.
  a_div_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIV))
    else $error("divider running outside the divide state");

  // A frame always completes on a low clock tick.
  a_raw_on_low_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_raw_valid) |-> !out_sck_level)
    else $error("raw code reported on a high clock tick");

  // A net value always comes with the raw code that completed it.
  a_net_with_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_net_valid) |-> out_raw_valid)
    else $error("net value without raw code");

  // The code count never exceeds the largest average.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    EFF_W'(cnt_r) < EFF_W'(MAX_AVERAGE))
    else $error("code count out of range");

endmodule

// ===== test/tb_bridge_adc_serial_reader_top.sv =====
// Self-checking testbench for the bridge converter serial reader top level.
`timescale 1ns / 1ps
module tb_bridge_adc_serial_reader_top;
  import badc_pkg::*;

  localparam int AVG_LIMIT   = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 4;
  localparam int RANDOM_TICKS = 350;
  localparam int BURST_CODES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic                    sck;
    logic                    raw_valid;
    logic [DATA_BITS-1:0]    raw_code;
    logic                    net_valid;
    logic signed [NET_W-1:0] net_value;
  } tick_result_t;

  // Predicts every tick of the serial reader and checks the results in order.
  class tick_scoreboard;
    logic [GAIN_W-1:0]    gain_pulses;
    logic [AVG_W-1:0]     avg_count;
    logic [CFG_W-1:0]     tare_offset;
    logic [1:0]           frame_phase;
    logic [PULSE_W-1:0]   pulse_idx;
    logic                 clk_high;
    logic [DATA_BITS-1:0] shift_word;
    logic [29:0]          code_sum;
    logic [AVG_W-1:0]     codes_taken;
    tick_result_t         expected_ticks[$];
    int                   errors;
    int                   results_seen;

    function new();
      gain_pulses  = 2'd1;
      avg_count    = 7'd1;
      tare_offset  = '0;
      frame_phase  = PH_IDLE;
      pulse_idx    = '0;
      clk_high     = 1'b0;
      shift_word   = '0;
      code_sum     = '0;
      codes_taken  = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    // Register writes take effect at once; unknown indexes are dropped.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_GAIN_PULSES:   gain_pulses = data[GAIN_W-1:0];
        CFG_AVERAGE_COUNT: avg_count   = data[AVG_W-1:0];
        CFG_TARE_OFFSET:   tare_offset = data;
        default: ;
      endcase
    endfunction

    // Ends a frame: emits the raw code and, once enough codes are in, the net value.
    function void close_frame(inout tick_result_t r);
      logic [DATA_BITS-1:0] raw;
      logic [AVG_W-1:0]     eff;
      logic [29:0]          mean;
      raw         = shift_word ^ TOP_BIT;
      frame_phase = PH_IDLE;
      pulse_idx   = '0;
      r.raw_valid = 1'b1;
      r.raw_code  = raw;
      code_sum    = code_sum + {6'd0, raw};
      codes_taken = codes_taken + 7'd1;
      if (avg_count == 0) begin
        eff = 7'd1;
      end else if (avg_count > AVG_LIMIT) begin
        eff = 7'(AVG_LIMIT);
      end else begin
        eff = avg_count;
      end
      if (codes_taken >= eff) begin
        mean        = code_sum / {23'd0, codes_taken};
        r.net_valid = 1'b1;
        r.net_value = {1'b0, mean[DATA_BITS-1:0]} - {1'b0, tare_offset};
        code_sum    = '0;
        codes_taken = '0;
      end
    endfunction

    // Advances the predicted state by one accepted tick and queues its result.
    function void note_input(logic level);
      tick_result_t r;
      r = '0;
      if (frame_phase == PH_IDLE) begin
        if (!level) begin
          frame_phase = PH_DATA;
          pulse_idx   = '0;
          clk_high    = 1'b0;
          shift_word  = '0;
        end
      end else if (!clk_high) begin
        r.sck    = 1'b1;
        clk_high = 1'b1;
      end else begin
        clk_high = 1'b0;
        if (frame_phase == PH_DATA) begin
          shift_word = {shift_word[DATA_BITS-2:0], level};
          pulse_idx  = pulse_idx + 5'd1;
          if (pulse_idx >= DATA_BITS) begin
            pulse_idx = '0;
            if (gain_pulses == 0) begin
              close_frame(r);
            end else begin
              frame_phase = PH_GAIN;
            end
          end
        end else begin
          pulse_idx = pulse_idx + 5'd1;
          if (pulse_idx >= gain_pulses) begin
            close_frame(r);
          end
        end
      end
      expected_ticks.push_back(r);
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
      errors++;
    endtask

    // Compares one accepted result with the oldest expectation, field by field.
    task check_result(tick_result_t got);
      tick_result_t want;
      results_seen++;
      if (expected_ticks.size() == 0) begin
        report("result with nothing pending, sck_level", 32'(got.sck), 32'd0);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.sck !== want.sck)
        report("sck_level", 32'(got.sck), 32'(want.sck));
      if (got.raw_valid !== want.raw_valid)
        report("raw_valid", 32'(got.raw_valid), 32'(want.raw_valid));
      if (got.raw_code !== want.raw_code)
        report("raw_code", 32'(got.raw_code), 32'(want.raw_code));
      if (got.net_valid !== want.net_valid)
        report("net_valid", 32'(got.net_valid), 32'(want.net_valid));
      if (got.net_value !== want.net_value)
        report("net_value", 32'(got.net_value), 32'(want.net_value));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_dout_level = 1'b1;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_sck_level;
  logic                    out_raw_valid;
  logic [DATA_BITS-1:0]    out_raw_code;
  logic                    out_net_valid;
  logic signed [NET_W-1:0] out_net_value;

  logic hold_off = 1'b0;
  bit   hold_request = 1'b0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  int   rx_wait = 0;
  int   ticks_sent = 0;
  tick_result_t seen;

  tick_scoreboard sb = new();

  bridge_adc_serial_reader_top #(
    .MAX_AVERAGE(AVG_LIMIT)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_dout_level(in_dout_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sck_level(out_sck_level),
    .out_raw_valid(out_raw_valid),
    .out_raw_code (out_raw_code),
    .out_net_valid(out_net_valid),
    .out_net_value(out_net_value)
  );

  // Free-running 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check every accepted item, then stall for a random spell.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.sck       = out_sck_level;
      seen.raw_valid = out_raw_valid;
      seen.raw_code  = out_raw_code;
      seen.net_valid = out_net_valid;
      seen.net_value = out_net_value;
      sb.check_result(seen);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
    end
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long receiver hold-off so that the block fills up and stalls its input.
  initial begin
    wait (hold_request);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  // Offers one tick after a random gap and waits until it is taken.
  task automatic send_tick(input logic level);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_dout_level <= level;
    do @(posedge clk); while (in_stall);
    sb.note_input(level);
    ticks_sent++;
  endtask

  // A well-formed frame: start tick, then a high and a low tick per pulse.
  task automatic send_frame(input logic [DATA_BITS-1:0] word, input int extra);
    send_tick(1'b0);
    for (int i = 0; i < DATA_BITS + extra; i++) begin
      send_tick(1'($urandom_range(0, 1)));
      if (i < DATA_BITS) begin
        send_tick(word[DATA_BITS-1-i]);
      end else begin
        send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_BITS-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h800000;
      3:       return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Main stimulus sequence.
  initial begin : stimulus
    int                   phase_no;
    int                   segs;
    int                   choice;
    int                   base;
    logic [AVG_W-1:0]     avg_pick;
    logic [CFG_W-1:0]     tare_pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Idle ticks with the data line high are ignored; then defaults after reset.
    send_tick(1'b1);
    send_tick(1'b1);
    send_frame(24'h000000, sb.gain_pulses);
    send_frame(24'hFFFFFF, sb.gain_pulses);

    // No gain pulses, an average count of zero and the largest tare.
    wait_drained();
    set_reg(CFG_GAIN_PULSES, 24'd0);
    set_reg(CFG_AVERAGE_COUNT, 24'd0);
    set_reg(CFG_TARE_OFFSET, 24'hFFFFFF);
    send_frame(24'h800000, sb.gain_pulses);
    send_frame(24'h7FFFFF, sb.gain_pulses);

    // Over-large average count, then lowered while codes are still summed.
    wait_drained();
    set_reg(CFG_GAIN_PULSES, 24'd3);
    set_reg(CFG_AVERAGE_COUNT, 24'd127);
    set_reg(CFG_TARE_OFFSET, 24'd0);
    set_reg(CFG_UNUSED_INDEX, 24'hFFFFFF);
    repeat (3) send_frame(pick_word(), sb.gain_pulses);
    wait_drained();
    set_reg(CFG_AVERAGE_COUNT, 24'd2);
    send_frame(pick_word(), sb.gain_pulses);

    // Gain lowered after two of three gain pulses: the next pulse ends the frame.
    wait_drained();
    set_reg(CFG_AVERAGE_COUNT, 24'd1);
    send_frame(pick_word(), 2);
    wait_drained();
    set_reg(CFG_GAIN_PULSES, 24'd1);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
    set_reg(CFG_GAIN_PULSES, 24'd2);
    send_frame(pick_word(), sb.gain_pulses);

    // A multi-code average taken back to back, without idling on either side.
    wait_drained();
    set_reg(CFG_GAIN_PULSES, 24'd0);
    set_reg(CFG_AVERAGE_COUNT, 24'(BURST_CODES));
    set_reg(CFG_TARE_OFFSET, 24'($urandom));
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (BURST_CODES) send_frame(24'($urandom), sb.gain_pulses);

    // Random phases with random settings, frames and line noise.
    base     = ticks_sent;
    phase_no = 0;
    while (ticks_sent < base + RANDOM_TICKS) begin
      wait_drained();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1))
        set_reg(CFG_GAIN_PULSES, 24'($urandom));
      if ($urandom_range(0, 1)) begin
        choice = $urandom_range(0, 9);
        if (choice < 6) begin
          avg_pick = 7'($urandom_range(1, 3));
        end else if (choice == 6) begin
          avg_pick = 7'd0;
        end else begin
          avg_pick = 7'($urandom_range(0, 4));
        end
        set_reg(CFG_AVERAGE_COUNT, (24'($urandom) & 24'hFFFF80) | {17'd0, avg_pick});
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 3))
          0:       tare_pick = 24'd0;
          1:       tare_pick = 24'hFFFFFF;
          default: tare_pick = 24'($urandom);
        endcase
        set_reg(CFG_TARE_OFFSET, tare_pick);
      end
      if ($urandom_range(0, 7) == 0)
        set_reg(CFG_UNUSED_INDEX, 24'($urandom));
      if (phase_no == 0)
        hold_request = 1'b1;

      segs = $urandom_range(3, 8);
      for (int s = 0; s < segs; s++) begin
        if ($urandom_range(0, 4) == 0) begin
          // Line noise: starts frames at arbitrary points.
          repeat ($urandom_range(1, 40)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          while (sb.frame_phase != PH_IDLE) send_tick(1'($urandom_range(0, 1)));
          repeat ($urandom_range(0, 3)) send_tick(1'b1);
          send_frame(pick_word(), sb.gain_pulses);
        end
        if ($urandom_range(0, 7) == 0)
          wait_drained();
      end
      phase_no++;
    end

    // Let the last results out, then report.
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0)
      sb.report("results still pending", 32'(sb.pending()), 32'd0);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== bridge_adc_serial_reader_top.f =====
sv/badc_pkg.sv
sv/badc_frame.sv
sv/badc_div.sv
sv/bridge_adc_serial_reader_top.sv
test/tb_bridge_adc_serial_reader_top.sv
